// ===== design/edw_pkg.sv =====
// ----------------------------------------------------------------------------
// Edge detect window filter package
// Pixel type, configuration register indexes and reset values, and the
// control bundle passed from the column stage to the window stage.
// ----------------------------------------------------------------------------
`default_nettype none

package edw_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int ROW_W      = 10;
  localparam int MAX_HEIGHT = 1024;

  typedef logic [PIX_W-1:0] pixel_t;

  localparam logic CFG_LINE_LEN   = 1'b0;
  localparam logic CFG_FRAME_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef struct packed {
    logic valid;
    logic first_col;
  } col_ctrl_t;

endpackage

`default_nettype wire

// ===== design/edw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module edw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/edw_column.sv =====
// ----------------------------------------------------------------------------
// Edge detect column stage
// Builds the new window column from the line buffer word and the incoming
// pixel, replicating the top row, and forms the shifted line buffer word,
// the column sum and the centre row value.
// ----------------------------------------------------------------------------
`default_nettype none

module edw_column import edw_pkg::*; #(
  parameter int RADIUS = 2
) (
  input  pixel_t                      px,
  input  logic [ROW_W-1:0]            row,
  input  logic [2*RADIUS*PIX_W-1:0]   rd_data,
  input  logic                        fwd_en,
  input  logic [2*RADIUS*PIX_W-1:0]   fwd_data,
  output logic [2*RADIUS*PIX_W-1:0]   wr_data,
  output pixel_t                      center,
  output logic [$clog2((2*RADIUS+1)*255+1)-1:0] col_sum
);

  localparam int LINES = 2 * RADIUS;
  localparam int WIN   = 2 * RADIUS + 1;
  localparam int CSW   = $clog2(WIN * 255 + 1);
  localparam int YS_W  = $clog2(LINES + 1);

  logic [LINES*PIX_W-1:0] src_data;
  logic [YS_W-1:0]        ys;
  pixel_t                 rows [LINES];
  pixel_t                 vec  [WIN];

  assign src_data = fwd_en ? fwd_data : rd_data;
  assign ys = (row >= ROW_W'(LINES)) ? YS_W'(LINES) : row[YS_W-1:0];

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      rows[k] = src_data[k*PIX_W +: PIX_W];
    end
    wr_data[PIX_W-1:0] = px;
    for (int k = 1; k < LINES; k++) begin
      wr_data[k*PIX_W +: PIX_W] = rows[k-1];
    end
  end

  // replicate the top row where the window reaches above row 0
  always_comb begin
    int src;
    src = 0;
    for (int d = 0; d < WIN; d++) begin
      src = (d < int'(ys)) ? d : int'(ys);
      vec[d] = px;
      for (int k = 0; k < LINES; k++) begin
        if (k + 1 == src) begin
          vec[d] = rows[k];
        end
      end
    end
  end

  always_comb begin
    col_sum = '0;
    for (int d = 0; d < WIN; d++) begin
      col_sum = col_sum + CSW'(vec[d]);
    end
  end

  assign center = vec[RADIUS];

endmodule

`default_nettype wire

// ===== design/edw_window.sv =====
// ----------------------------------------------------------------------------
// Edge detect window stage
// Holds the column sums and centre row of the window, keeps a running window
// total, and clamps the Laplacian response into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module edw_window import edw_pkg::*; #(
  parameter int RADIUS = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  col_ctrl_t                             col_ctrl,
  input  pixel_t                                center,
  input  logic [$clog2((2*RADIUS+1)*255+1)-1:0] col_sum,
  output logic                                  ready,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output pixel_t                                edge_value
);

  localparam int WIN = 2 * RADIUS + 1;
  localparam int CSW = $clog2(WIN * 255 + 1);
  localparam int TW  = $clog2(WIN * WIN * 255 + 1);

  pixel_t            ctr [RADIUS+1];
  logic [CSW-1:0]    cs  [WIN];
  logic [TW-1:0]     total;
  logic              w_valid;
  logic              out_load;
  logic              take;
  logic [TW-1:0]     prod;
  logic signed [TW:0] acc;
  pixel_t            clamped;

  assign out_load = w_valid && (!out_valid || !out_stall);
  assign ready    = !w_valid || out_load;
  assign take     = col_ctrl.valid && ready;

  always_ff @(posedge clk) begin
    if (take) begin
      if (col_ctrl.first_col) begin
        for (int i = 0; i <= RADIUS; i++) begin
          ctr[i] <= center;
        end
        for (int i = 0; i < WIN; i++) begin
          cs[i] <= col_sum;
        end
        total <= TW'(WIN) * TW'(col_sum);
      end else begin
        for (int i = 0; i < RADIUS; i++) begin
          ctr[i] <= ctr[i+1];
        end
        ctr[RADIUS] <= center;
        for (int i = 0; i < WIN - 1; i++) begin
          cs[i] <= cs[i+1];
        end
        cs[WIN-1] <= col_sum;
        total <= total - TW'(cs[0]) + TW'(col_sum);
      end
    end
  end

  always_comb begin
    prod = TW'(WIN * WIN) * TW'(ctr[0]);
    acc  = $signed({1'b0, prod}) - $signed({1'b0, total});
    if (acc[TW]) begin
      clamped = '0;
    end else if (acc[TW-1:0] > TW'(255)) begin
      clamped = 8'hFF;
    end else begin
      clamped = acc[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        w_valid <= 1'b1;
      end else if (out_load) begin
        w_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      edge_value <= clamped;
    end
  end

endmodule

`default_nettype wire

// ===== design/edge_detect_window_filter.sv =====
// ----------------------------------------------------------------------------
// Edge detect window filter
// Streaming (2R+1)x(2R+1) Laplacian over raster-order 8-bit pixels, with
// line buffers for the previous 2R rows and replication at the top and left.
//
//   channel   signals                              direction
//   pixel     in_valid, in_stall, pixel_in         in
//   result    out_valid, out_stall, edge_value     out
//   config    cfg_write, cfg_index, cfg_data       in
//
// One pixel per clock sustained while out_stall stays low; each result
// passes through the registered line buffer read and the window stage.
// Line buffers are a single RAM, one word per column, read and written once
// per pixel; a write to the column read at the same edge is forwarded.
// Reset clears the row and column counters and loads the default image size.
// A stalled result is held in the output register, one more in the window
// stage and one in the column stage; in_stall rises only when all three are
// full.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_detect_window_filter import edw_pkg::*; #(
  parameter int RADIUS    = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pixel_t           pixel_in,
  output logic             out_valid,
  input  logic             out_stall,
  output pixel_t           edge_value,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LINES = 2 * RADIUS;
  localparam int WIN   = 2 * RADIUS + 1;
  localparam int LW    = LINES * PIX_W;
  localparam int CSW   = $clog2(WIN * 255 + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

  logic [CFG_W-1:0] line_len;
  logic [CFG_W-1:0] frame_rows;
  logic [CW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [WW-1:0]    width_eff;
  logic [CFG_W-1:0] height_eff;
  logic             col_last;
  logic             row_last;
  logic             in_accept;

  logic             s1_valid;
  logic             s1_adv;
  pixel_t           s1_px;
  logic [ROW_W-1:0] s1_y;
  logic             s1_first;
  logic [CW-1:0]    s1_addr;
  logic             s1_fwd;
  logic [LW-1:0]    s1_fwd_data;

  logic [LW-1:0]    ram_rd;
  logic [LW-1:0]    line_wr;
  pixel_t           col_center;
  logic [CSW-1:0]   col_sum;
  logic             win_ready;
  col_ctrl_t        ctrl;

  always_comb begin
    if (line_len == '0) begin
      width_eff = WW'(1);
    end else if (WW'(line_len) > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(line_len);
    end
    if (frame_rows == '0) begin
      height_eff = CFG_W'(1);
    end else if (frame_rows > CFG_W'(MAX_HEIGHT)) begin
      height_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_rows;
    end
  end

  assign col_last  = (WW'(col_cnt) + WW'(1)) >= width_eff;
  assign row_last  = (CFG_W'(row_cnt) + CFG_W'(1)) >= height_eff;
  assign s1_adv    = s1_valid && win_ready;
  assign in_stall  = s1_valid && !win_ready;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len   <= WIDTH_RESET;
      frame_rows <= HEIGHT_RESET;
      col_cnt    <= '0;
      row_cnt    <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_LINE_LEN:   line_len   <= cfg_data;
          CFG_FRAME_ROWS: frame_rows <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        if (col_last) begin
          col_cnt <= '0;
          row_cnt <= row_last ? '0 : row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // forward the word written this cycle when the next read hits the same column
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px       <= pixel_in;
      s1_y        <= row_cnt;
      s1_first    <= (col_cnt == '0);
      s1_addr     <= col_cnt;
      s1_fwd      <= s1_adv && (s1_addr == col_cnt);
      s1_fwd_data <= line_wr;
    end
  end

  edw_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (line_wr),
    .rd_en   (in_accept),
    .rd_addr (col_cnt),
    .rd_data (ram_rd)
  );

  edw_column #(
    .RADIUS(RADIUS)
  ) u_column (
    .px       (s1_px),
    .row      (s1_y),
    .rd_data  (ram_rd),
    .fwd_en   (s1_fwd),
    .fwd_data (s1_fwd_data),
    .wr_data  (line_wr),
    .center   (col_center),
    .col_sum  (col_sum)
  );

  assign ctrl = {s1_valid, s1_first};

  edw_window #(
    .RADIUS(RADIUS)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .col_ctrl   (ctrl),
    .center     (col_center),
    .col_sum    (col_sum),
    .ready      (win_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_value (edge_value)
  );

endmodule

`default_nettype wire

// ===== dv/edge_detect_window_filter_tb.sv =====
// ----------------------------------------------------------------------------
// Edge detect window filter testbench
// Drives raster-order pixels through the filter under random idling on both
// channels and compares each result with an internal model of the window,
// the line buffers and the row and column counters. Image sizes change only
// at frame ends or by lowering them mid-frame, so no unwritten line buffer
// entry is ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edge_detect_window_filter_tb import edw_pkg::*;;

  localparam int RAD         = 2;
  localparam int WIN         = 2 * RAD + 1;
  localparam int LINES       = 2 * RAD;
  localparam int MAX_W       = 1024;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1800;

  class edge_scoreboard;
    pixel_t            line_mem [LINES][MAX_W];
    pixel_t            win_regs [WIN][WIN];
    int unsigned       col;
    int unsigned       row;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    pixel_t            edge_q [$];
    int unsigned       num_noted;
    int unsigned       num_checked;
    int unsigned       fails;

    function new();
      col = 0;
      row = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      num_noted = 0;
      num_checked = 0;
      fails = 0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] v);
      if (idx == CFG_LINE_LEN) width_reg = v;
      else height_reg = v;
    endfunction

    function int pending();
      return edge_q.size();
    endfunction

    // pixels still needed to bring both counters back to zero
    function int unsigned frame_remaining();
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      int unsigned n;
      w = clamp_size(32'(width_reg), MAX_W);
      h = clamp_size(32'(height_reg), MAX_HEIGHT);
      x = col;
      y = row;
      n = 0;
      while (n == 0 || x != 0 || y != 0) begin
        if (x == 0 && y == 0) break;
        n++;
        if (x + 1 >= w) begin
          x = 0;
          y = (y + 1 >= h) ? 0 : y + 1;
        end else begin
          x = x + 1;
        end
      end
      return n;
    endfunction

    function void note_pixel(pixel_t p);
      int unsigned w;
      int unsigned h;
      int          x;
      int          y;
      int          xi;
      int          src;
      int          total;
      int          acc;
      pixel_t      column_vec [WIN];
      pixel_t      v;
      w = clamp_size(32'(width_reg), MAX_W);
      h = clamp_size(32'(height_reg), MAX_HEIGHT);
      x = col;
      y = row;
      xi = (x < MAX_W) ? x : MAX_W - 1;
      for (int d = 0; d < WIN; d++) begin
        src = (d <= y) ? d : y;
        column_vec[d] = (src == 0) ? p : line_mem[src-1][xi];
      end
      for (int k = LINES - 1; k > 0; k--) line_mem[k][xi] = line_mem[k-1][xi];
      line_mem[0][xi] = p;
      for (int r = 0; r < WIN; r++) begin
        v = column_vec[WIN-1-r];
        if (x == 0) begin
          for (int c = 0; c < WIN; c++) win_regs[r][c] = v;
        end else begin
          for (int c = 0; c < WIN - 1; c++) win_regs[r][c] = win_regs[r][c+1];
          win_regs[r][WIN-1] = v;
        end
      end
      total = 0;
      for (int r = 0; r < WIN; r++)
        for (int c = 0; c < WIN; c++) total += int'(win_regs[r][c]);
      acc = WIN * WIN * int'(win_regs[RAD][RAD]) - total;
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      edge_q.push_back(pixel_t'(acc));
      num_noted++;
      if (x + 1 >= w) begin
        col = 0;
        row = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col = x + 1;
      end
    endfunction

    function void check_edge(pixel_t got);
      pixel_t exp_val;
      num_checked++;
      if (edge_q.size() == 0) begin
        $error("edge_value: unexpected transaction, actual %0d", got);
        fails++;
        return;
      end
      exp_val = edge_q.pop_front();
      if (got !== exp_val) begin
        $error("edge_value mismatch: expected %0d, actual %0d", exp_val, got);
        fails++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  pixel_t           pixel_in;
  logic             out_valid;
  logic             out_stall;
  pixel_t           edge_value;
  logic             cfg_write;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bit               no_gaps;
  bit               hold_req;
  int unsigned      sent_count;
  int unsigned      idle_cycles;

  edge_scoreboard sb = new();

  edge_detect_window_filter #(
    .RADIUS    (RAD),
    .MAX_WIDTH (MAX_W)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_value (edge_value),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_pixel(pixel_in);
      if (out_valid && !out_stall) sb.check_edge(edge_value);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    int unsigned hold_left;
    bit          held_once;
    hold_left = 0;
    held_once = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(0, 99) < 30);
      end
    end
  end

  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 3))
      0: return pixel_t'(0);
      1: return pixel_t'(255);
      default: return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic set_size(input int unsigned w, input int unsigned h);
    cfg_write <= 1'b1;
    cfg_index <= CFG_LINE_LEN;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    sb.write_reg(CFG_LINE_LEN, CFG_W'(w));
    cfg_index <= CFG_FRAME_ROWS;
    cfg_data  <= CFG_W'(h);
    @(posedge clk);
    sb.write_reg(CFG_FRAME_ROWS, CFG_W'(h));
    cfg_write <= 1'b0;
  endtask

  task automatic send_pixel(input pixel_t p);
    while (!no_gaps && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // drop valid and hold until every transaction has its result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.num_noted != sent_count || sb.pending() != 0) @(posedge clk);
  endtask

  // partial frame at large sizes, then lower them so a counter lies beyond
  task automatic lowered_size(input int unsigned w_big, input int unsigned h_big,
                              input int unsigned n, input int unsigned w_low,
                              input int unsigned h_low, input int unsigned frames);
    set_size(w_big, h_big);
    send_random(n);
    drain();
    set_size(w_low, h_low);
    send_random(sb.frame_remaining());
    send_random(frames * sb.clamp_size(w_low, MAX_W) * sb.clamp_size(h_low, MAX_HEIGHT));
    drain();
  endtask

  initial begin
    int unsigned phase_num;
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned frames;
    rst        = 1'b1;
    in_valid   = 1'b0;
    pixel_in   = '0;
    cfg_write  = 1'b0;
    cfg_index  = CFG_LINE_LEN;
    cfg_data   = '0;
    no_gaps    = 1'b0;
    hold_req   = 1'b0;
    sent_count = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // isolated bright centre, then isolated dark centre
    set_size(3, 3);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'd0);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd0 : 8'd255);
    drain();
    // zero sizes act as one pixel per frame
    set_size(0, 0);
    send_pixel(8'h55);
    send_pixel(8'haa);
    send_pixel(8'hff);
    send_pixel(8'h00);
    drain();

    hold_req <= 1'b1;
    lowered_size(1024, 0, 180, 5, 0, 4);
    lowered_size(2047, 1, 150, 2, 3, 2);
    lowered_size(3, 2047, 3 * 40 + 1, 3, 4, 3);
    lowered_size(4, 1024, 4 * 10 + 2, 4, 1, 5);

    phase_num = 0;
    while (sent_count < ITEM_TARGET) begin
      w_raw  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      h_raw  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      frames = $urandom_range(1, 3);
      no_gaps <= (phase_num == 3);
      set_size(w_raw, h_raw);
      send_random(frames * sb.clamp_size(w_raw, MAX_W) * sb.clamp_size(h_raw, MAX_HEIGHT));
      drain();
      phase_num++;
    end
    no_gaps <= 1'b0;

    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
